### src/ifri_pkg.sv
// ----------------------------------------------------------------------------
// ifri_pkg
// Shared types and constants for the image flip/rotate/invert frame engine.
// ----------------------------------------------------------------------------
package ifri_pkg;

  // Default frame store geometry
  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;

  // Field widths
  localparam int DimW     = 9;
  localparam int PixW     = 8;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 9;
  localparam int StoreW   = 3 * PixW;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 8'd1;
  localparam logic [CfgIdxW-1:0] RegColourMode  = 8'd2;
  localparam logic [CfgIdxW-1:0] RegTransform   = 8'd3;

  // Register reset values
  localparam logic [DimW-1:0] ImageWidthRst  = 9'd256;
  localparam logic [DimW-1:0] ImageHeightRst = 9'd256;
  localparam logic            ColourModeRst  = 1'b1;

  // Request opcodes
  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  // Transform codes; the unused codes pass pixels through
  typedef enum logic [2:0] {
    XF_INVERT   = 3'd0,
    XF_MIRROR_H = 3'd1,
    XF_MIRROR_V = 3'd2,
    XF_ROT90    = 3'd3,
    XF_ROT270   = 3'd4
  } transform_e;

endpackage

### src/ifri_pix_in_if.sv
// ----------------------------------------------------------------------------
// ifri_pix_in_if
// Request channel: load a pixel or read the next transformed pixel.
// ----------------------------------------------------------------------------
interface ifri_pix_in_if;
  import ifri_pkg::*;

  logic            valid;
  logic            ready;
  logic            opcode;
  logic [PixW-1:0] in_red;
  logic [PixW-1:0] in_green;
  logic [PixW-1:0] in_blue;

  modport source (output valid, output opcode, output in_red, output in_green,
                  output in_blue, input ready);
  modport sink   (input valid, input opcode, input in_red, input in_green,
                  input in_blue, output ready);
endinterface

### src/ifri_pix_out_if.sv
// ----------------------------------------------------------------------------
// ifri_pix_out_if
// Result channel: one transformed pixel with frame size and status.
// ----------------------------------------------------------------------------
interface ifri_pix_out_if;
  import ifri_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] out_red;
  logic [PixW-1:0] out_green;
  logic [PixW-1:0] out_blue;
  logic            last_pixel;
  logic [DimW-1:0] out_width;
  logic [DimW-1:0] out_height;
  logic            read_status;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output last_pixel, output out_width, output out_height,
                  output read_status, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input last_pixel, input out_width, input out_height,
                  input read_status, output ready);
endinterface

### src/ifri_cfg_if.sv
// ----------------------------------------------------------------------------
// ifri_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ifri_cfg_if;
  import ifri_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/image_flip_rotate_invert_top.sv
// ----------------------------------------------------------------------------
// image_flip_rotate_invert_top
// Frame store with inverting, mirroring and rotating read-out.
// ----------------------------------------------------------------------------
// Load requests fill the frame store in raster order; once width*height
// pixels are in, read requests return the transformed frame in output raster
// order and the read of the last pixel re-arms the store for the next frame.
// One request is taken every cycle unless stalled; a read result passes through
// the address multiply into the store's registered read port, then the
// result register, and a load gives no result. Back-pressure on the
// result channel stalls the request channel only once both pipeline stages
// are full. The store is not cleared after reset and needs no clearing pass.
// Configuration writes are always ready and must only be issued while idle.
// ----------------------------------------------------------------------------
module image_flip_rotate_invert_top #(
  parameter int MAX_WIDTH  = ifri_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = ifri_pkg::MaxHeightDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ifri_pix_in_if.sink    pix_in_i,
  ifri_pix_out_if.source pix_out_o,
  ifri_cfg_if.sink       cfg_i
);
  import ifri_pkg::*;

  localparam int StoreDepth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int CntW       = $clog2(StoreDepth + 1);
  localparam int ProdW      = 2 * DimW;
  localparam int SumW       = (AddrW > ProdW) ? AddrW : ProdW;
  localparam int TotW       = (CntW > ProdW) ? CntW : ProdW;
  localparam logic [DimW-1:0] WidthMax  = (MAX_WIDTH > 511)  ? 9'd511 : 9'(MAX_WIDTH);
  localparam logic [DimW-1:0] HeightMax = (MAX_HEIGHT > 511) ? 9'd511 : 9'(MAX_HEIGHT);

  // Configuration registers
  logic [DimW-1:0] image_width_q, image_height_q;
  logic            colour_mode_q;
  logic [2:0]      transform_q;

  // Frame state
  logic [CntW-1:0] load_count_q, load_count_d;
  logic            frame_full_q, frame_full_d;
  logic [DimW-1:0] read_row_q, read_row_d, read_col_q, read_col_d;

  // Read stage (store data arrives here) and result register
  logic            s1_valid_q, s1_status_q, s1_last_q, s1_invert_q, s1_rgb_q;
  logic [DimW-1:0] s1_ow_q, s1_oh_q;
  logic            out_valid_q;
  logic [PixW-1:0] out_red_q, out_green_q, out_blue_q;
  logic            out_last_q, out_status_q;
  logic [DimW-1:0] out_width_q, out_height_q;

  // Datapath signals
  logic [DimW-1:0]  w, h, ow, oh, r, c, sr, sc;
  logic [ProdW-1:0] total, prod;
  logic [SumW-1:0]  addr_sum;
  logic             rotate, full_eff, last, rgb;
  logic             in_acc, is_load, is_read, s1_adv;
  logic [StoreW-1:0] wdata, rdata;
  logic [PixW-1:0]  px_red, px_green, px_blue;

  // Configuration port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= ImageWidthRst;
      image_height_q <= ImageHeightRst;
      colour_mode_q  <= ColourModeRst;
      transform_q    <= XF_INVERT;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegImageWidth:  image_width_q  <= cfg_i.data[DimW-1:0];
        RegImageHeight: image_height_q <= cfg_i.data[DimW-1:0];
        RegColourMode:  colour_mode_q  <= cfg_i.data[0];
        RegTransform:   transform_q    <= cfg_i.data[2:0];
        default: ;
      endcase
    end
  end

  // Clamped sizes and output geometry
  always_comb begin
    if (image_width_q == '0)            w = 9'd1;
    else if (image_width_q > WidthMax)  w = WidthMax;
    else                                w = image_width_q;
    if (image_height_q == '0)           h = 9'd1;
    else if (image_height_q > HeightMax) h = HeightMax;
    else                                h = image_height_q;
  end

  assign rgb      = colour_mode_q;
  assign rotate   = (transform_q == XF_ROT90) || (transform_q == XF_ROT270);
  assign ow       = rotate ? h : w;
  assign oh       = rotate ? w : h;
  assign total    = w * h;
  assign full_eff = frame_full_q || (TotW'(load_count_q) >= TotW'(total));

  // Handshake: stage 1 drains into the result register when that is free
  assign s1_adv         = s1_valid_q && (!out_valid_q || pix_out_o.ready);
  assign pix_in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc         = pix_in_i.valid && pix_in_i.ready;
  assign is_load        = in_acc && (pix_in_i.opcode == OpLoad);
  assign is_read        = in_acc && (pix_in_i.opcode == OpRead);

  // Output position, clamped, and source position in the stored frame
  assign r    = (read_row_q < oh) ? read_row_q : oh - 9'd1;
  assign c    = (read_col_q < ow) ? read_col_q : ow - 9'd1;
  assign last = (r == oh - 9'd1) && (c == ow - 9'd1);

  always_comb begin
    case (transform_q)
      XF_MIRROR_H: begin sr = r;             sc = w - 9'd1 - c; end
      XF_MIRROR_V: begin sr = h - 9'd1 - r;  sc = c;            end
      XF_ROT90:    begin sr = h - 9'd1 - c;  sc = r;            end
      XF_ROT270:   begin sr = c;             sc = w - 9'd1 - r; end
      default:     begin sr = r;             sc = c;            end
    endcase
  end

  assign prod     = sr * w;
  assign addr_sum = SumW'(prod) + SumW'(sc);

  // Stored word: gray mode keeps only the first channel
  assign wdata = {pix_in_i.in_red,
                  rgb ? pix_in_i.in_green : 8'd0,
                  rgb ? pix_in_i.in_blue  : 8'd0};

  ifri_ram #(
    .WIDTH (StoreW),
    .DEPTH (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (is_load && !full_eff),
    .waddr_i (load_count_q[AddrW-1:0]),
    .wdata_i (wdata),
    .re_i    (is_read),
    .raddr_i (addr_sum[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // Frame counters
  always_comb begin
    load_count_d = load_count_q;
    frame_full_d = full_eff;
    read_row_d   = read_row_q;
    read_col_d   = read_col_q;
    if (is_load && !full_eff) begin
      load_count_d = load_count_q + 1'b1;
      frame_full_d = TotW'(load_count_d) >= TotW'(total);
    end else if (is_read && full_eff) begin
      if (last) begin
        load_count_d = '0;
        frame_full_d = 1'b0;
        read_row_d   = '0;
        read_col_d   = '0;
      end else if (c == ow - 9'd1) begin
        read_col_d = '0;
        read_row_d = r + 9'd1;
      end else begin
        read_col_d = c + 9'd1;
        read_row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
      frame_full_q <= 1'b0;
      read_row_q   <= '0;
      read_col_q   <= '0;
    end else if (in_acc) begin
      load_count_q <= load_count_d;
      frame_full_q <= frame_full_d;
      read_row_q   <= read_row_d;
      read_col_q   <= read_col_d;
    end
  end

  // Stage 1: request side info that travels with the store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_in_i.ready) begin
      s1_valid_q <= is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_read) begin
      s1_status_q <= !full_eff;
      s1_last_q   <= full_eff && last;
      s1_invert_q <= transform_q == XF_INVERT;
      s1_rgb_q    <= rgb;
      s1_ow_q     <= ow;
      s1_oh_q     <= oh;
    end
  end

  // Pixel transform on the store data
  always_comb begin
    px_red   = s1_invert_q ? ~rdata[23:16] : rdata[23:16];
    px_green = s1_invert_q ? ~rdata[15:8]  : rdata[15:8];
    px_blue  = s1_invert_q ? ~rdata[7:0]   : rdata[7:0];
    if (!s1_rgb_q) begin
      px_green = '0;
      px_blue  = '0;
    end
    if (s1_status_q) begin
      px_red   = '0;
      px_green = '0;
      px_blue  = '0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (pix_out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_red_q    <= px_red;
      out_green_q  <= px_green;
      out_blue_q   <= px_blue;
      out_last_q   <= s1_last_q;
      out_status_q <= s1_status_q;
      out_width_q  <= s1_ow_q;
      out_height_q <= s1_oh_q;
    end
  end

  assign pix_out_o.valid       = out_valid_q;
  assign pix_out_o.out_red     = out_red_q;
  assign pix_out_o.out_green   = out_green_q;
  assign pix_out_o.out_blue    = out_blue_q;
  assign pix_out_o.last_pixel  = out_last_q;
  assign pix_out_o.out_width   = out_width_q;
  assign pix_out_o.out_height  = out_height_q;
  assign pix_out_o.read_status = out_status_q;

endmodule

### src/ifri_ram.sv
// ----------------------------------------------------------------------------
// ifri_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ifri_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the image flip/rotate/invert frame engine.
// ----------------------------------------------------------------------------
// A short directed table covers reset status, size clamping, grayscale,
// loads into a full frame, reads of a partial frame, a rotation, an unused
// pass-through transform code and a write to an unused register. Random
// frames follow, mostly load-then-read sequences of random size and pixel
// content, mixed with early reads, surplus loads and register changes in
// the middle of a frame. Every read request is predicted by an in-bench
// frame model or its checked table row; each result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ifri_pkg::*;

  localparam int unsigned StoreDepth = MaxWidthDef * MaxHeightDef;
  localparam int unsigned ItemsTarget = 1300;
  localparam int unsigned IdlePct = 13;
  localparam int unsigned SteadyFrom = 600;
  localparam int unsigned SteadyTo = 850;
  localparam int unsigned HoldAt = 900;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned PipeDrain = 4;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned MaxFramePx = 512;
  localparam int unsigned ReportMax = 10;
  localparam logic [PixW-1:0] FullScale = 8'd255;
  localparam logic [2:0] XfCodeMax = 3'd7;
  localparam logic [CfgIdxW-1:0] RegUnused = 8'd200;

  // One result of a read request
  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    logic            last;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            status;
  } pix_res_t;

  localparam pix_res_t NoRes = '0;

  // Directed stimulus rows
  typedef enum logic [1:0] {
    RowCfg,
    RowReq,
    RowReqChk
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic                 op;
    logic [PixW-1:0]      red;
    logic [PixW-1:0]      green;
    logic [PixW-1:0]      blue;
    pix_res_t             want;
  } row_t;

  localparam int NumRows = 30;

  row_t dir_rows [NumRows] = '{
    // read right after reset: not loaded, default 256x256
    '{RowReqChk, 8'd0, 9'd0, OpRead, 8'd0, 8'd0, 8'd0,
      '{8'd0, 8'd0, 8'd0, 1'b0, 9'd256, 9'd256, 1'b1}},
    // 1x1 grayscale invert, width 0 clamps to 1
    '{RowCfg, RegImageWidth, 9'd0, OpLoad, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowCfg, RegImageHeight, 9'd1, OpLoad, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowCfg, RegColourMode, 9'd0, OpLoad, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowCfg, RegTransform, 9'(XF_INVERT), OpLoad, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowReq, 8'd0, 9'd0, OpLoad, 8'd255, 8'hAA, 8'h55, NoRes},
    // frame already full: this load is dropped
    '{RowReq, 8'd0, 9'd0, OpLoad, 8'h12, 8'h34, 8'h56, NoRes},
    '{RowReqChk, 8'd0, 9'd0, OpRead, 8'd0, 8'd0, 8'd0,
      '{8'd0, 8'd0, 8'd0, 1'b1, 9'd1, 9'd1, 1'b0}},
    // write to an unused index has no effect
    '{RowCfg, RegUnused, 9'h1FF, OpLoad, 8'd0, 8'd0, 8'd0, NoRes},
    // 2x2 RGB rotate 90
    '{RowCfg, RegImageWidth, 9'd2, OpLoad, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowCfg, RegImageHeight, 9'd2, OpLoad, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowCfg, RegColourMode, 9'd1, OpLoad, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowCfg, RegTransform, 9'(XF_ROT90), OpLoad, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowReq, 8'd0, 9'd0, OpLoad, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowReq, 8'd0, 9'd0, OpLoad, 8'd255, 8'd255, 8'd255, NoRes},
    // partial frame read
    '{RowReqChk, 8'd0, 9'd0, OpRead, 8'd0, 8'd0, 8'd0,
      '{8'd0, 8'd0, 8'd0, 1'b0, 9'd2, 9'd2, 1'b1}},
    '{RowReq, 8'd0, 9'd0, OpLoad, 8'h0F, 8'hF0, 8'h5A, NoRes},
    '{RowReq, 8'd0, 9'd0, OpLoad, 8'hA5, 8'h3C, 8'hC3, NoRes},
    '{RowReq, 8'd0, 9'd0, OpRead, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowReq, 8'd0, 9'd0, OpRead, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowReq, 8'd0, 9'd0, OpRead, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowReq, 8'd0, 9'd0, OpRead, 8'd0, 8'd0, 8'd0, NoRes},
    // 2x1 with an unused transform code: pixels pass through
    '{RowCfg, RegTransform, 9'(XfCodeMax), OpLoad, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowCfg, RegImageHeight, 9'd1, OpLoad, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowReq, 8'd0, 9'd0, OpLoad, 8'h81, 8'h42, 8'h24, NoRes},
    '{RowReq, 8'd0, 9'd0, OpRead, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowReq, 8'd0, 9'd0, OpLoad, 8'h7E, 8'hBD, 8'hDB, NoRes},
    '{RowReq, 8'd0, 9'd0, OpRead, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowReq, 8'd0, 9'd0, OpRead, 8'd0, 8'd0, 8'd0, NoRes},
    '{RowReq, 8'd0, 9'd0, OpLoad, 8'h00, 8'hFF, 8'h00, NoRes}
  };

  logic clk_i;
  logic rst_ni;

  ifri_pix_in_if  pix_in ();
  ifri_pix_out_if pix_out ();
  ifri_cfg_if     cfg ();

  image_flip_rotate_invert_top u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_in_i  (pix_in),
    .pix_out_o (pix_out),
    .cfg_i     (cfg)
  );

  // Frame model state
  logic [StoreW-1:0]   frame_mem [StoreDepth];
  int unsigned         fill_cnt;
  int unsigned         fill_peak;
  int unsigned         row_ptr;
  int unsigned         col_ptr;
  bit                  full_q;
  logic [DimW-1:0]     cfg_width;
  logic [DimW-1:0]     cfg_height;
  logic                cfg_rgb;
  logic [2:0]          cfg_xf;

  pix_res_t            pending_pix [$];
  int unsigned         req_cnt;
  int unsigned         fail_cnt;
  int unsigned         stall_cnt;
  int unsigned         holds_asked;
  int unsigned         holds_served;
  bit                  steady;
  pix_res_t            got_pix;
  pix_res_t            want_pix;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_dim(logic [DimW-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned frame_px(logic [DimW-1:0] w, logic [DimW-1:0] h);
    return eff_dim(w, MaxWidthDef) * eff_dim(h, MaxHeightDef);
  endfunction

  // A size change must never lead to a read of a store entry never loaded
  function automatic bit size_safe(logic [DimW-1:0] w, logic [DimW-1:0] h);
    int unsigned px;
    px = frame_px(w, h);
    return px <= MaxFramePx && (!full_q || px <= fill_peak);
  endfunction

  // Random dimension: mostly small, sometimes zero or at or beyond the maximum
  function automatic logic [DimW-1:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return '0;
    if (roll < 5) return DimW'($urandom_range(256, 511));
    if (roll < 90) return DimW'($urandom_range(1, 8));
    return DimW'($urandom_range(9, 20));
  endfunction

  // Frame model: one accepted request, optional result
  task automatic frame_step(input logic op, input logic [PixW-1:0] r, g, b,
                            output bit has_res, output pix_res_t res);
    int unsigned w, h, total, ow, oh, rr, cc, sr, sc, addr;
    bit rot;
    logic [StoreW-1:0] pix;
    w = eff_dim(cfg_width, MaxWidthDef);
    h = eff_dim(cfg_height, MaxHeightDef);
    total = w * h;
    rot = (cfg_xf == XF_ROT90) || (cfg_xf == XF_ROT270);
    ow = rot ? h : w;
    oh = rot ? w : h;
    has_res = 1'b0;
    res = '0;

    if (!full_q && fill_cnt >= total) full_q = 1'b1;

    // load
    if (op == OpLoad) begin
      if (!full_q) begin
        frame_mem[fill_cnt] = {r, cfg_rgb ? g : 8'd0, cfg_rgb ? b : 8'd0};
        fill_cnt++;
        if (fill_cnt > fill_peak) fill_peak = fill_cnt;
        if (fill_cnt >= total) full_q = 1'b1;
      end
      return;
    end

    // read
    has_res = 1'b1;
    res.width = DimW'(ow);
    res.height = DimW'(oh);
    if (!full_q) begin
      res.status = 1'b1;
      return;
    end

    rr = row_ptr < oh ? row_ptr : oh - 1;
    cc = col_ptr < ow ? col_ptr : ow - 1;
    case (cfg_xf)
      XF_MIRROR_H: begin sr = rr;         sc = w - 1 - cc; end
      XF_MIRROR_V: begin sr = h - 1 - rr; sc = cc;         end
      XF_ROT90:    begin sr = h - 1 - cc; sc = rr;         end
      XF_ROT270:   begin sr = cc;         sc = w - 1 - rr; end
      default:     begin sr = rr;         sc = cc;         end
    endcase
    addr = sr * w + sc;
    pix = frame_mem[addr];
    res.red = pix[23:16];
    res.green = pix[15:8];
    res.blue = pix[7:0];
    if (cfg_xf == XF_INVERT) begin
      res.red = FullScale - res.red;
      res.green = FullScale - res.green;
      res.blue = FullScale - res.blue;
    end
    if (!cfg_rgb) begin
      res.green = '0;
      res.blue = '0;
    end
    res.last = (rr == oh - 1) && (cc == ow - 1);

    // advance output raster position
    if (res.last) begin
      row_ptr = 0;
      col_ptr = 0;
      fill_cnt = 0;
      full_q = 1'b0;
    end else if (cc + 1 >= ow) begin
      col_ptr = 0;
      row_ptr = rr + 1;
    end else begin
      col_ptr = cc + 1;
      row_ptr = rr;
    end
  endtask

  // Issue one request; predicted result goes to the pending queue
  task automatic send_pixel(input logic op, input logic [PixW-1:0] r, g, b,
                            input bit typed, input pix_res_t typed_res,
                            output bit ends_frame);
    bit has_res;
    pix_res_t res;
    while (!steady && $urandom_range(99) < IdlePct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.opcode <= op;
    pix_in.in_red <= r;
    pix_in.in_green <= g;
    pix_in.in_blue <= b;
    do @(posedge clk_i); while (!pix_in.ready);
    req_cnt++;
    frame_step(op, r, g, b, has_res, res);
    if (has_res) pending_pix.push_back(typed ? typed_res : res);
    ends_frame = has_res && res.last;
  endtask

  // Register write, only once the engine has drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    pix_in.valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk_i);
    repeat (PipeDrain) @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      RegImageWidth:  cfg_width = data;
      RegImageHeight: cfg_height = data;
      RegColourMode:  cfg_rgb = data[0];
      RegTransform:   cfg_xf = data[2:0];
      default: ;
    endcase
  endtask

  // Register change in the middle of a frame
  task automatic tweak_config();
    logic [DimW-1:0] d;
    int unsigned sel;
    sel = $urandom_range(3);
    d = DimW'($urandom_range(1, 8));
    if (sel == 0 && size_safe(d, cfg_height)) write_reg(RegImageWidth, d);
    else if (sel == 1 && size_safe(cfg_width, d)) write_reg(RegImageHeight, d);
    else if (sel == 2) write_reg(RegColourMode, CfgDataW'($urandom_range(1)));
    else write_reg(RegTransform, CfgDataW'($urandom_range(XfCodeMax)));
  endtask

  // One random frame, from the first load to the read of its last pixel
  task automatic run_frame(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
                           inout bit hold_done);
    bit done;
    int unsigned roll;
    logic op;
    write_reg(RegImageWidth, w);
    write_reg(RegImageHeight, h);
    write_reg(RegColourMode, CfgDataW'($urandom_range(1)));
    write_reg(RegTransform, CfgDataW'($urandom_range(XfCodeMax)));
    done = 1'b0;
    while (!done) begin
      steady = (req_cnt >= SteadyFrom) && (req_cnt < SteadyTo);
      // hold only at the start of a read-out, so enough reads follow to fill up
      if (!hold_done && full_q && req_cnt >= HoldAt && row_ptr == 0 && col_ptr == 0 &&
          frame_px(cfg_width, cfg_height) >= 4) begin
        holds_asked++;
        hold_done = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 2) begin
        tweak_config();
      end else begin
        if (!full_q) op = (roll < 7) ? OpRead : OpLoad;
        else op = (roll < 6) ? OpLoad : OpRead;
        send_pixel(op, PixW'($urandom_range(255)), PixW'($urandom_range(255)),
                   PixW'($urandom_range(255)), 1'b0, NoRes, done);
      end
    end
  endtask

  // Mismatch reporting
  task automatic check_field(input string name, input logic [DimW-1:0] want,
                             input logic [DimW-1:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= ReportMax)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      got_pix = '{pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                  pix_out.last_pixel, pix_out.out_width, pix_out.out_height,
                  pix_out.read_status};
      if (pending_pix.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= ReportMax)
          $display("%0t: result with no read request pending", $realtime);
      end else begin
        want_pix = pending_pix.pop_front();
        check_field("out_red", DimW'(want_pix.red), DimW'(got_pix.red));
        check_field("out_green", DimW'(want_pix.green), DimW'(got_pix.green));
        check_field("out_blue", DimW'(want_pix.blue), DimW'(got_pix.blue));
        check_field("last_pixel", DimW'(want_pix.last), DimW'(got_pix.last));
        check_field("out_width", want_pix.width, got_pix.width);
        check_field("out_height", want_pix.height, got_pix.height);
        check_field("read_status", DimW'(want_pix.status), DimW'(got_pix.status));
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
        (cfg.valid && cfg.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Result channel back-pressure, with one long hold on request
  initial begin
    pix_out.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (holds_served != holds_asked) begin
        holds_served++;
        pix_out.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        pix_out.ready <= steady || ($urandom_range(99) >= IdlePct);
        @(posedge clk_i);
      end
    end
  end

  // Main stimulus
  initial begin : stim
    bit ends;
    bit hold_done;
    logic [DimW-1:0] w, h;
    int unsigned frame_idx;

    rst_ni <= 1'b0;
    pix_in.valid <= 1'b0;
    pix_in.opcode <= OpLoad;
    pix_in.in_red <= '0;
    pix_in.in_green <= '0;
    pix_in.in_blue <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    stall_cnt = 0;
    req_cnt = 0;
    fail_cnt = 0;
    holds_asked = 0;
    holds_served = 0;
    steady = 1'b0;
    hold_done = 1'b0;
    fill_cnt = 0;
    fill_peak = 0;
    row_ptr = 0;
    col_ptr = 0;
    full_q = 1'b0;
    cfg_width = ImageWidthRst;
    cfg_height = ImageHeightRst;
    cfg_rgb = ColourModeRst;
    cfg_xf = XF_INVERT;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        RowCfg: write_reg(dir_rows[i].idx, dir_rows[i].data);
        RowReq: send_pixel(dir_rows[i].op, dir_rows[i].red, dir_rows[i].green,
                           dir_rows[i].blue, 1'b0, NoRes, ends);
        default: send_pixel(dir_rows[i].op, dir_rows[i].red, dir_rows[i].green,
                            dir_rows[i].blue, 1'b1, dir_rows[i].want, ends);
      endcase
    end

    // random frames; the first one is the tallest frame
    frame_idx = 0;
    while (req_cnt < ItemsTarget || !hold_done) begin
      if (frame_idx == 0) begin
        w = '0;
        h = 9'd511;
      end else begin
        w = pick_dim();
        h = pick_dim();
        if (frame_px(w, h) > MaxFramePx) begin
          if ($urandom_range(1)) h = DimW'($urandom_range(1, 2));
          else w = DimW'($urandom_range(1, 2));
        end
      end
      run_frame(w, h, hold_done);
      frame_idx++;
    end

    // drain
    steady = 1'b0;
    pix_in.valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
